// ===== rtl/per_source_connection_rate_limiter_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the per-source connection rate limiter
// ---------------------------------------------------------------------------
`ifndef PER_SOURCE_CONNECTION_RATE_LIMITER_ASSERT_SVH
`define PER_SOURCE_CONNECTION_RATE_LIMITER_ASSERT_SVH

// clocked on aclk, off while aresetn is low
`define PSRL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("rate limiter check failed");

// clocked on aclk, also checked through reset
`define PSRL_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("rate limiter reset check failed");

`endif

// ===== rtl/psrl_pkg.sv =====
// ---------------------------------------------------------------------------
// psrl_pkg
// Shared widths, register codes and the token/commit word types of the
// per-source connection rate limiter.
// ---------------------------------------------------------------------------
`default_nettype none

package psrl_pkg;

    localparam int ADDR_W     = 32;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 8;
    localparam int WINDOW_W   = 16;
    localparam int LIMIT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS   = 2'd1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd15;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 8'd5;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 8'hFF;

    // lookup word walking down the cell chain
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  addr;
        logic [TIME_W-1:0]  now;
        logic               hit;
        logic               spare;
        logic [COUNT_W-1:0] hit_count;
        logic               hit_expired;
    } psrl_token_t;

    // table update broadcast to all cells
    typedef struct packed {
        logic               en;
        logic               use_hit;
        logic               restart;
        logic [ADDR_W-1:0]  addr;
        logic [TIME_W-1:0]  now;
        logic [COUNT_W-1:0] count;
    } psrl_commit_t;

endpackage

`default_nettype wire

// ===== rtl/psrl_cell.sv =====
// ---------------------------------------------------------------------------
// psrl_cell
// One table entry. Compares the passing lookup word against its entry,
// marks itself as first hit or first spare, and applies the broadcast update.
// ---------------------------------------------------------------------------
`default_nettype none

module psrl_cell (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [psrl_pkg::WINDOW_W-1:0]   window_seconds,
    input  wire psrl_pkg::psrl_token_t           tok_in,
    output psrl_pkg::psrl_token_t                tok_out,
    input  wire psrl_pkg::psrl_commit_t          commit
);

    logic                             valid_reg;
    logic [psrl_pkg::ADDR_W-1:0]      addr_reg;
    logic [psrl_pkg::COUNT_W-1:0]     count_reg;
    logic [psrl_pkg::TIME_W-1:0]      start_reg;
    logic                             mark_hit_reg;
    logic                             mark_spare_reg;
    psrl_pkg::psrl_token_t            tok_reg;
    psrl_pkg::psrl_token_t            tok_next;

    logic [psrl_pkg::TIME_W-1:0]      elapsed;
    logic                             expired;
    logic                             match;
    logic                             first_hit;
    logic                             first_spare;
    logic                             selected;

    assign elapsed     = tok_in.now - start_reg;
    assign expired     = elapsed > {{(psrl_pkg::TIME_W-psrl_pkg::WINDOW_W){1'b0}},
                                    window_seconds};
    assign match       = valid_reg && (addr_reg == tok_in.addr);
    assign first_hit   = tok_in.valid && !tok_in.hit && match;
    assign first_spare = tok_in.valid && !tok_in.spare && (!valid_reg || expired);
    assign selected    = commit.use_hit ? mark_hit_reg : mark_spare_reg;

    always_comb begin
        tok_next       = tok_in;
        tok_next.hit   = tok_in.hit | match;
        tok_next.spare = tok_in.spare | (!valid_reg || expired);
        if (first_hit) begin
            tok_next.hit_count   = count_reg;
            tok_next.hit_expired = expired;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            mark_hit_reg   <= 1'b0;
            mark_spare_reg <= 1'b0;
            tok_reg        <= '0;
        end else begin
            tok_reg <= tok_next;
            if (tok_in.valid) begin
                mark_hit_reg   <= first_hit;
                mark_spare_reg <= first_spare;
            end
            if (commit.en && selected) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit.en && selected) begin
            addr_reg  <= commit.addr;
            count_reg <= commit.count;
            if (commit.restart) begin
                start_reg <= commit.now;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== rtl/per_source_connection_rate_limiter.sv =====
// ---------------------------------------------------------------------------
// per_source_connection_rate_limiter
// Fixed-window connection rate limiter keyed by source IPv4 address.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per connection attempt (source address, time in
//   seconds). m_ channel: one word per attempt (allowed, attempt count,
//   untracked). cfg_we/cfg_index/cfg_wdata write window_seconds (index 0)
//   and max_attempts (index 1); other indexes are ignored.
//   The lookup word walks the chain of TABLE_ENTRIES cells, one cell per
//   cycle, and lands in the tail register; from there the result and the
//   table update are formed, the result into the output register.
//   One attempt is in flight at a time, so the time an attempt takes is
//   set by the length of the cell chain.
//   s_ready is high while no attempt is in flight, even while a result
//   waits on m_ready. A stalled receiver holds the finished lookup at the
//   chain tail until the output register frees, which holds off s_ready.
//   Reset (aresetn low, synchronous) empties the table and restores
//   window_seconds 15 and max_attempts 5; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module per_source_connection_rate_limiter #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [psrl_pkg::ADDR_W-1:0]       s_source_address,
    input  wire logic [psrl_pkg::TIME_W-1:0]       s_now_seconds,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_allowed,
    output logic [psrl_pkg::COUNT_W-1:0]           m_attempt_count,
    output logic                                   m_untracked,
    input  wire logic                              cfg_we,
    input  wire logic [psrl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [psrl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [psrl_pkg::WINDOW_W-1:0]  window_reg;
    logic [psrl_pkg::LIMIT_W-1:0]   limit_reg;
    logic                           busy_reg;
    psrl_pkg::psrl_token_t          tail_reg;
    logic                           m_valid_reg;
    logic                           allowed_reg;
    logic [psrl_pkg::COUNT_W-1:0]   count_out_reg;
    logic                           untracked_reg;

    psrl_pkg::psrl_token_t          tok [TABLE_ENTRIES+1];
    psrl_pkg::psrl_token_t          head_tok;
    psrl_pkg::psrl_commit_t         commit;

    logic                           accept;
    logic                           finish;
    logic                           tracked;
    logic [psrl_pkg::COUNT_W-1:0]   base_count;
    logic [psrl_pkg::COUNT_W-1:0]   new_count;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    // retire the lookup once the output register is free
    assign finish  = tail_reg.valid && (!m_valid_reg || m_ready);

    always_comb begin
        head_tok           = '0;
        head_tok.valid     = accept;
        head_tok.addr      = s_source_address;
        head_tok.now       = s_now_seconds;
    end

    assign tok[0] = head_tok;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        psrl_cell u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .window_seconds (window_reg),
            .tok_in         (tok[g]),
            .tok_out        (tok[g+1]),
            .commit         (commit)
        );
    end

    assign tracked    = tail_reg.hit || tail_reg.spare;
    assign base_count = (tail_reg.hit && !tail_reg.hit_expired) ? tail_reg.hit_count
                                                                : '0;
    assign new_count  = (base_count == psrl_pkg::COUNT_MAX) ? base_count
                                                            : base_count + 8'd1;

    always_comb begin
        commit         = '0;
        commit.en      = finish && tracked;
        commit.use_hit = tail_reg.hit;
        commit.restart = !tail_reg.hit || tail_reg.hit_expired;
        commit.addr    = tail_reg.addr;
        commit.now     = tail_reg.now;
        commit.count   = new_count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg     <= psrl_pkg::WINDOW_RESET;
            limit_reg      <= psrl_pkg::LIMIT_RESET;
            busy_reg       <= 1'b0;
            tail_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    psrl_pkg::REG_WINDOW_SECONDS: window_reg <= cfg_wdata;
                    psrl_pkg::REG_MAX_ATTEMPTS:
                        limit_reg <= cfg_wdata[psrl_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (finish) begin
                busy_reg <= 1'b0;
            end
            if (tok[TABLE_ENTRIES].valid) begin
                tail_reg <= tok[TABLE_ENTRIES];
            end else if (finish) begin
                tail_reg.valid <= 1'b0;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            allowed_reg   <= !tracked || !(new_count > limit_reg);
            count_out_reg <= tracked ? new_count : '0;
            untracked_reg <= !tracked;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_allowed       = allowed_reg;
    assign m_attempt_count = count_out_reg;
    assign m_untracked     = untracked_reg;

endmodule

`default_nettype wire

// ===== rtl/psrl_checker.sv =====
// ---------------------------------------------------------------------------
// psrl_checker
// Port-level checks on the rate limiter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "per_source_connection_rate_limiter_assert.svh"

module psrl_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    input  wire logic                              s_ready,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire logic                              m_allowed,
    input  wire logic [psrl_pkg::COUNT_W-1:0]      m_attempt_count,
    input  wire logic                              m_untracked
);

    // a full table admits and reports no count
    `PSRL_ASSERT(a_untracked_admits, m_valid && m_untracked |-> m_allowed && (m_attempt_count == '0))
    // a tracked attempt always counts itself
    `PSRL_ASSERT(a_tracked_counts, m_valid && !m_untracked |-> m_attempt_count != '0)
    // one attempt in flight: no accept right after an accept
    `PSRL_ASSERT(a_one_in_flight, s_valid && s_ready |=> !s_ready)
    // a stalled result word holds
    `PSRL_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_attempt_count) && $stable(m_allowed))
    `PSRL_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid)

endmodule

bind per_source_connection_rate_limiter psrl_checker u_psrl_checker (.*);

`default_nettype wire

// ===== dv/tb_per_source_connection_rate_limiter.sv =====
// ---------------------------------------------------------------------------
// tb_per_source_connection_rate_limiter
// Self-checking bench for the per-source connection rate limiter. Attempts
// are scored against a local copy of the address table at accept time, and
// each result word is checked in order. Directed attempts cover window
// boundaries, time wrap and a full table. Random bursts then run under
// several window and limit settings with varied idling and one long
// receiver stall.
// ---------------------------------------------------------------------------
module tb_per_source_connection_rate_limiter;

    localparam int SLOTS        = 16;
    localparam int LONG_STALL   = 400;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    // indexes the block must ignore
    localparam logic [psrl_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [psrl_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic [psrl_pkg::ADDR_W-1:0] addr;
        logic [psrl_pkg::TIME_W-1:0] now;
    } attempt_t;

    typedef struct packed {
        logic                         allowed;
        logic [psrl_pkg::COUNT_W-1:0] count;
        logic                         untracked;
    } verdict_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic [psrl_pkg::ADDR_W-1:0]       s_source_address = '0;
    logic [psrl_pkg::TIME_W-1:0]       s_now_seconds = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic                              m_allowed;
    logic [psrl_pkg::COUNT_W-1:0]      m_attempt_count;
    logic                              m_untracked;
    logic                              cfg_we = 1'b0;
    logic [psrl_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [psrl_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

    // predictor state
    logic                            tbl_valid [SLOTS];
    logic [psrl_pkg::ADDR_W-1:0]     tbl_addr  [SLOTS];
    logic [psrl_pkg::COUNT_W-1:0]    tbl_count [SLOTS];
    logic [psrl_pkg::TIME_W-1:0]     tbl_start [SLOTS];
    logic [psrl_pkg::WINDOW_W-1:0]   win_len = psrl_pkg::WINDOW_RESET;
    logic [psrl_pkg::LIMIT_W-1:0]    attempt_limit = psrl_pkg::LIMIT_RESET;

    attempt_t      attempt_q [$];
    verdict_t      verdict_q [$];
    int            items_queued = 0;
    int            results_seen = 0;
    int            mismatches = 0;
    int            cycle_count = 0;
    logic          s_taken = 1'b0;
    int            send_idle_pct = 14;
    int            recv_idle_pct = 48;
    int            stall_req = 0;
    int            stall_ack = 0;
    int            stall_left = 0;
    logic [psrl_pkg::TIME_W-1:0] clock_now = '0;

    per_source_connection_rate_limiter #(
        .TABLE_ENTRIES(SLOTS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_source_address(s_source_address),
        .s_now_seconds   (s_now_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_allowed       (m_allowed),
        .m_attempt_count (m_attempt_count),
        .m_untracked     (m_untracked),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic window_over(input logic [psrl_pkg::TIME_W-1:0] start,
                                         input logic [psrl_pkg::TIME_W-1:0] now);
        logic [psrl_pkg::TIME_W-1:0] age;
        age = now - start;
        return age > psrl_pkg::TIME_W'(win_len);
    endfunction

    // scores one attempt and updates the table copy
    function automatic verdict_t rate_decision(input logic [psrl_pkg::ADDR_W-1:0] addr,
                                               input logic [psrl_pkg::TIME_W-1:0] now);
        verdict_t                     v;
        int                           slot;
        logic [psrl_pkg::COUNT_W-1:0] c;
        slot = -1;
        for (int i = 0; i < SLOTS; i++)
            if (slot < 0 && tbl_valid[i] && tbl_addr[i] == addr)
                slot = i;
        if (slot < 0) begin
            for (int i = 0; i < SLOTS; i++)
                if (slot < 0 && (!tbl_valid[i] || window_over(tbl_start[i], now)))
                    slot = i;
            if (slot < 0) begin
                // table full: admitted but not tracked
                v.allowed   = 1'b1;
                v.count     = '0;
                v.untracked = 1'b1;
                return v;
            end
            tbl_valid[slot] = 1'b1;
            tbl_addr[slot]  = addr;
            tbl_count[slot] = '0;
            tbl_start[slot] = now;
        end else if (window_over(tbl_start[slot], now)) begin
            tbl_count[slot] = '0;
            tbl_start[slot] = now;
        end
        c = tbl_count[slot];
        if (c != psrl_pkg::COUNT_MAX)
            c = c + 1'b1;
        tbl_count[slot] = c;
        v.allowed   = !(c > attempt_limit);
        v.count     = c;
        v.untracked = 1'b0;
        return v;
    endfunction

    // input driver
    always @(negedge aclk) begin : drv
        attempt_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (attempt_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = attempt_q.pop_front();
                s_valid          <= 1'b1;
                s_source_address <= nxt.addr;
                s_now_seconds    <= nxt.now;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver backpressure; long stalls are counted here
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_req != stall_ack) begin
            stall_ack  <= stall_req;
            stall_left <= LONG_STALL;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin : mon
        verdict_t got;
        verdict_t want;
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            verdict_q.push_back(rate_decision(s_source_address, s_now_seconds));
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            got.allowed   = m_allowed;
            got.count     = m_attempt_count;
            got.untracked = m_untracked;
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d with no attempt pending: %s%0b count %0d %s%0b",
                             results_seen, "allowed ", got.allowed, got.count,
                             "untracked ", got.untracked);
            end else begin
                want = verdict_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("result %0d: allowed exp %0b got %0b, %s%0d got %0d, %s%0b got %0b",
                                 results_seen, want.allowed, got.allowed,
                                 "count exp ", want.count, got.count,
                                 "untracked exp ", want.untracked, got.untracked);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("per_source_connection_rate_limiter verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [psrl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [psrl_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            psrl_pkg::REG_WINDOW_SECONDS: win_len = val;
            psrl_pkg::REG_MAX_ATTEMPTS:   attempt_limit = val[psrl_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_attempt(input logic [psrl_pkg::ADDR_W-1:0] addr,
                                input logic [psrl_pkg::TIME_W-1:0] now);
        attempt_t a;
        a.addr = addr;
        a.now  = now;
        attempt_q.push_back(a);
        items_queued++;
    endtask

    task automatic await_drain();
        while (results_seen != items_queued)
            @(negedge aclk);
    endtask

    // mostly a small address pool with slowly advancing time; wild_pct of
    // the words jump time around or use a fresh address
    task automatic queue_burst(input int n, input int pool_n, input int wild_pct);
        logic [psrl_pkg::ADDR_W-1:0] pool [$];
        for (int i = 0; i < pool_n; i++)
            pool.push_back($urandom);
        @(posedge aclk);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < wild_pct) begin
                case ($urandom_range(3))
                    0: clock_now = clock_now + $urandom_range(3 * win_len + 8);
                    1: clock_now = $urandom;
                    2: clock_now = clock_now - $urandom_range(20, 1);
                    default: clock_now = clock_now + $urandom_range(win_len + 2);
                endcase
                push_attempt($urandom_range(1) ? $urandom : pool[$urandom_range(pool_n - 1)],
                             clock_now);
            end else begin
                clock_now = clock_now + $urandom_range(2);
                push_attempt(pool[$urandom_range(pool_n - 1)], clock_now);
            end
        end
    endtask

    task automatic run_phase(input logic [psrl_pkg::WINDOW_W-1:0] w,
                             input logic [psrl_pkg::LIMIT_W-1:0] m,
                             input int send_pct, input int recv_pct,
                             input int pool_n, input int n, input int wild_pct);
        await_drain();
        write_reg(psrl_pkg::REG_WINDOW_SECONDS, w);
        write_reg(psrl_pkg::REG_MAX_ATTEMPTS, {8'($urandom), m});
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
        clock_now = $urandom;
        queue_burst(n, pool_n, wild_pct);
    endtask

    initial begin : stim
        for (int i = 0; i < SLOTS; i++)
            tbl_valid[i] = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: window 15, limit 5
        @(posedge aclk);
        for (int t = 100; t <= 105; t++)
            push_attempt(32'hC0A8_0001, t);
        push_attempt(32'hC0A8_0001, 32'd115);    // exactly window old: same window
        push_attempt(32'hC0A8_0001, 32'd116);    // one past: restarts
        push_attempt(32'h0000_0000, 32'hFFFF_FFFE);
        push_attempt(32'h0000_0000, 32'h0000_0003); // time wrapped, same window
        push_attempt(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // long window so nothing expires: fill the table and overflow it
        await_drain();
        write_reg(psrl_pkg::REG_WINDOW_SECONDS, 16'hFFFF);
        write_reg(psrl_pkg::REG_MAX_ATTEMPTS, 16'h37FE);
        @(posedge aclk);
        for (int i = 0; i < 17; i++)
            push_attempt(32'h0A00_0100 + i, 32'd5000);

        run_phase(16'd15, 8'd5, 14, 48, 20, 200, 15);
        // receiver holds off while words keep coming
        repeat (60) @(negedge aclk);
        stall_req <= stall_req + 1;

        run_phase(16'd0, 8'd0, 14, 48, 6, 80, 15);

        await_drain();
        write_reg(REG_SPARE_A, 16'($urandom));
        write_reg(REG_SPARE_B, 16'($urandom));

        // one address, no expiry: count saturates
        run_phase(16'hFFFF, 8'd255, 48, 14, 1, 270, 0);
        run_phase(16'd1, 8'd1, 0, 0, 12, 120, 20);
        run_phase(16'd300, 8'd254, 0, 0, 30, 140, 10);
        run_phase(16'd7, 8'd3, 0, 0, 16, 100, 25);

        await_drain();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("per_source_connection_rate_limiter verification clean");
        else
            $display("per_source_connection_rate_limiter verification failed");
        $finish;
    end

endmodule
